[hw/rtl/oaht_pkg.sv]
// Package for the open-addressing hash table: word layouts, field widths,
// status and command codes. No dependencies.
`default_nettype none
package oaht_pkg;

  localparam int TABLE_SIZE_W = 11;
  localparam int COURSE_W     = 16;
  localparam int YEAR_W       = 12;
  localparam int PROF_W       = 32;
  localparam int HANDLE_W     = 16;
  localparam int STATUS_W     = 2;
  localparam int SLOT_W       = 10;
  localparam int PROBE_W      = 11;

  localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1024;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                command;
    logic [COURSE_W-1:0] course_number;
    logic [YEAR_W-1:0]   course_year;
    logic [PROF_W-1:0]   prof_code;
    logic [HANDLE_W-1:0] record_handle;
  } oaht_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [PROBE_W-1:0]  probe_count;
    logic                collided;
    logic [HANDLE_W-1:0] found_handle;
  } oaht_out_t;

  typedef struct packed {
    logic                valid;
    logic [YEAR_W-1:0]   course_year;
    logic [COURSE_W-1:0] course_number;
    logic [PROF_W-1:0]   prof_code;
    logic [HANDLE_W-1:0] record_handle;
  } oaht_entry_t;

  localparam int ENTRY_W = $bits(oaht_entry_t);

  typedef struct packed {
    logic init;
    logic step;
  } oaht_probe_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/open_addressing_hash_table.sv]
// Top level of the open-addressing hash table with quadratic probing.
// Depends on oaht_pkg, oaht_ram, oaht_mod and oaht_probe.
//
// Usage: a command word (insert or search) is taken on in_data at a clock
// edge where start is high and busy is low. Busy stays high until the
// result word has been produced; the result appears on out_data for one
// cycle with out_valid high and must be taken then, as the receiver cannot
// stall it. Each command yields exactly one result word.
// From acceptance, the bit-serial remainder unit computes the home slot, which
// is loaded into the probe unit; then each probe, of which there are from one
// to the table size, reads its slot through the slot memory's registered read
// port. A new command may be taken in the cycle that the result is shown.
// The size register is written through cfg_we and cfg_data; the user should
// write it only while idle, which the block itself does not enforce. Values of
// zero act as one and values above TABLE_DEPTH as TABLE_DEPTH.
// After reset the block runs a clearing pass over every slot of the slot
// memory with busy high; configuration writes are taken during it.
`default_nettype none
module open_addressing_hash_table
  import oaht_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  oaht_in_t               in_data,
  output logic                   out_valid,
  output oaht_out_t              out_data,
  input  wire                    cfg_we,
  input  wire [TABLE_SIZE_W-1:0] cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int SW = IW + 1;
  localparam int CW = (SW > TABLE_SIZE_W) ? SW : TABLE_SIZE_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [TABLE_SIZE_W-1:0] table_size_r, table_size_nxt;
  logic [IW-1:0]           clr_r, clr_nxt;
  oaht_in_t                item_r, item_nxt;
  logic [SW-1:0]           size_r, size_nxt;
  logic [SW-1:0]           home_r, home_nxt;
  logic [SW-1:0]           probes_r, probes_nxt;
  logic                    coll_r, coll_nxt;
  logic                    out_valid_r, out_valid_nxt;
  oaht_out_t               out_r, out_nxt;

  logic [CW-1:0]   ts_w;
  logic [SW-1:0]   eff_size;
  logic            accept;
  logic            mod_done;
  logic [SW-1:0]   mod_rem;
  oaht_probe_ctl_t probe_ctl;
  logic [SW-1:0]   pos;
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  oaht_entry_t     ram_wdata;
  oaht_entry_t     ram_rdata;
  logic            match;

  always_comb begin
    ts_w = CW'(table_size_r);
    if (ts_w == '0) begin
      ts_w = CW'(1);
    end else if (ts_w > CW'(TABLE_DEPTH)) begin
      ts_w = CW'(TABLE_DEPTH);
    end
    eff_size = SW'(ts_w);
  end

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  oaht_mod #(.SW(SW)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .dividend  (in_data.course_number),
    .divisor   (eff_size),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  oaht_probe #(.SW(SW)) u_probe (
    .clk  (clk),
    .ctl  (probe_ctl),
    .home (mod_rem),
    .size (size_r),
    .pos  (pos)
  );

  oaht_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign match = (ram_rdata.course_year == item_r.course_year) &&
                 (ram_rdata.course_number == item_r.course_number) &&
                 (ram_rdata.prof_code == item_r.prof_code);

  always_comb begin
    state_nxt      = state_r;
    table_size_nxt = cfg_we ? cfg_data : table_size_r;
    clr_nxt        = clr_r;
    item_nxt       = item_r;
    size_nxt       = size_r;
    home_nxt       = home_r;
    probes_nxt     = probes_r;
    coll_nxt       = coll_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    probe_ctl      = '0;
    ram_we         = 1'b0;
    ram_waddr      = pos[IW-1:0];
    ram_wdata      = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          size_nxt  = eff_size;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          probe_ctl.init = 1'b1;
          home_nxt       = mod_rem;
          probes_nxt     = '0;
          coll_nxt       = 1'b0;
          state_nxt      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (probes_r >= size_r) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = '0;
          out_nxt.probe_count  = PROBE_W'(probes_r);
          if (item_r.command == CMD_INSERT) begin
            out_nxt.status   = ST_FULL;
            out_nxt.collided = coll_r;
          end else begin
            out_nxt.status = ST_NOT_FOUND;
          end
          state_nxt = S_IDLE;
        end else if (item_r.command == CMD_SEARCH && probes_r != '0 && pos == home_r) begin
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.status      = ST_NOT_FOUND;
          out_nxt.probe_count = PROBE_W'(probes_r);
          state_nxt           = S_IDLE;
        end else begin
          probes_nxt = probes_r + 1'b1;
          state_nxt  = S_WAIT;
        end
      end
      S_WAIT: begin
        out_nxt             = '0;
        out_nxt.probe_count = PROBE_W'(probes_r);
        if (item_r.command == CMD_INSERT) begin
          if (!ram_rdata.valid) begin
            ram_we                  = 1'b1;
            ram_wdata.valid         = 1'b1;
            ram_wdata.course_year   = item_r.course_year;
            ram_wdata.course_number = item_r.course_number;
            ram_wdata.prof_code     = item_r.prof_code;
            ram_wdata.record_handle = item_r.record_handle;
            out_valid_nxt           = 1'b1;
            out_nxt.status          = ST_INSERTED;
            out_nxt.slot_index      = SLOT_W'(pos);
            out_nxt.collided        = coll_r;
            state_nxt               = S_IDLE;
          end else begin
            coll_nxt       = 1'b1;
            probe_ctl.step = 1'b1;
            state_nxt      = S_CHECK;
          end
        end else begin
          if (!ram_rdata.valid) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = ST_NOT_FOUND;
            state_nxt      = S_IDLE;
          end else if (match) begin
            out_valid_nxt        = 1'b1;
            out_nxt.status       = ST_FOUND;
            out_nxt.slot_index   = SLOT_W'(pos);
            out_nxt.found_handle = ram_rdata.record_handle;
            state_nxt            = S_IDLE;
          end else begin
            probe_ctl.step = 1'b1;
            state_nxt      = S_CHECK;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      table_size_r <= TABLE_SIZE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      table_size_r <= table_size_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    item_r   <= item_nxt;
    size_r   <= size_nxt;
    home_r   <= home_nxt;
    probes_r <= probes_nxt;
    coll_r   <= coll_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[hw/rtl/oaht_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/oaht_mod.sv]
// Iterative remainder unit: key mod table size, one quotient bit per cycle.
// Depends on oaht_pkg for the key width.
`default_nettype none
module oaht_mod
  import oaht_pkg::*;
#(
  parameter int SW = 11
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire [COURSE_W-1:0] dividend,
  input  wire [SW-1:0]       divisor,
  output logic               done,
  output logic [SW-1:0]      remainder
);

  localparam int CNT_W = $clog2(COURSE_W);

  logic                running_r, running_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [COURSE_W-1:0] dvd_r, dvd_nxt;
  logic [SW-1:0]       div_r, div_nxt;
  logic [SW-1:0]       rem_r, rem_nxt;
  logic [SW:0]         trial;

  always_comb begin
    running_nxt = running_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    dvd_nxt     = dvd_r;
    div_nxt     = div_r;
    rem_nxt     = rem_r;
    trial       = {rem_r, dvd_r[COURSE_W-1]};
    if (start) begin
      running_nxt = 1'b1;
      cnt_nxt     = CNT_W'(COURSE_W - 1);
      dvd_nxt     = dividend;
      div_nxt     = divisor;
      rem_nxt     = '0;
    end else if (running_r) begin
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_nxt = trial[SW-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        running_nxt = 1'b0;
        done_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      done_r    <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[hw/rtl/oaht_probe.sv]
// Probe position generator: cumulative quadratic steps kept modulo the size.
// Depends on oaht_pkg for the control word type.
`default_nettype none
module oaht_probe
  import oaht_pkg::*;
#(
  parameter int SW = 11
) (
  input  wire             clk,
  input  oaht_probe_ctl_t ctl,
  input  wire [SW-1:0]    home,
  input  wire [SW-1:0]    size,
  output logic [SW-1:0]   pos
);

  // kk holds k*k mod size, d holds (2k+1) mod size for the current k.
  logic [SW-1:0] pos_r, pos_nxt;
  logic [SW-1:0] kk_r, kk_nxt;
  logic [SW-1:0] d_r, d_nxt;
  logic [SW:0]   sum_pos, sum_kk, sum_d;
  logic [SW-1:0] one_mod, three_mod;

  always_comb begin
    one_mod   = (size == SW'(1)) ? '0 : SW'(1);
    three_mod = SW'(3);
    if (size == SW'(1) || size == SW'(3)) begin
      three_mod = '0;
    end else if (size == SW'(2)) begin
      three_mod = SW'(1);
    end

    sum_pos = {1'b0, pos_r} + {1'b0, kk_r};
    if (sum_pos >= {1'b0, size}) begin
      sum_pos = sum_pos - {1'b0, size};
    end
    sum_kk = {1'b0, kk_r} + {1'b0, d_r};
    if (sum_kk >= {1'b0, size}) begin
      sum_kk = sum_kk - {1'b0, size};
    end
    sum_d = {1'b0, d_r} + (SW + 1)'(2);
    if (sum_d >= {1'b0, size}) begin
      sum_d = sum_d - {1'b0, size};
    end
    if (sum_d >= {1'b0, size}) begin
      sum_d = sum_d - {1'b0, size};
    end

    pos_nxt = pos_r;
    kk_nxt  = kk_r;
    d_nxt   = d_r;
    if (ctl.init) begin
      pos_nxt = home;
      kk_nxt  = one_mod;
      d_nxt   = three_mod;
    end else if (ctl.step) begin
      pos_nxt = sum_pos[SW-1:0];
      kk_nxt  = sum_kk[SW-1:0];
      d_nxt   = sum_d[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    kk_r  <= kk_nxt;
    d_r   <= d_nxt;
  end

  assign pos = pos_r;

endmodule
`default_nettype wire

[hw/rtl/oaht_checker.sv]
// Port-level checker for the hash table, bound to the top level.
// Depends on oaht_pkg for word types and status codes.
`default_nettype none
module oaht_checker
  import oaht_pkg::*;
(
  input wire                    clk,
  input wire                    rst_n,
  input wire                    start,
  input wire                    busy,
  input wire                    out_valid,
  input oaht_out_t              out_data
);

  // Reset starts the clearing pass, so the block reports busy afterwards.
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after a word was accepted");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_handle_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_FOUND) |-> (out_data.found_handle == '0))
    else $error("handle reported without a match");

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_NOT_FOUND || out_data.status == ST_FULL))
    |-> (out_data.slot_index == '0 && out_data.probe_count != '0))
    else $error("bad slot or probe count on a miss");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (.*);
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for open_addressing_hash_table: command words are queued, driven
// with random gaps and checked field by field against a model of the probing table.
// Depends on oaht_pkg and the open_addressing_hash_table RTL.
`timescale 1ns / 1ps

module tb
  import oaht_pkg::*;
();

  localparam int TABLE_DEPTH = 1024;
  localparam int TAIL_CYCLES = 18 + 2 * TABLE_DEPTH + 64;

  typedef enum logic [1:0] {JOB_OP, JOB_CFG, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t                kind;
    oaht_in_t                 word;
    logic [TABLE_SIZE_W-1:0]  size;
    bit                       steady;
  } job_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  oaht_in_t                in_data = '0;
  logic                    out_valid;
  oaht_out_t               out_data;
  logic                    cfg_we = 1'b0;
  logic [TABLE_SIZE_W-1:0] cfg_data = '0;

  job_t                    cmd_plan[$];
  oaht_out_t               answer_q[$];
  bit                      in_taken;
  int                      error_count = 0;
  longint                  cycle_count = 0;
  longint                  cycle_limit = 64'h7fff_ffff_ffff;
  longint                  cycle_budget = 0;
  logic [TABLE_SIZE_W-1:0] planned_size = TABLE_SIZE_RESET;

  logic [TABLE_SIZE_W-1:0] size_reg = TABLE_SIZE_RESET;
  bit                      slot_used [TABLE_DEPTH];
  oaht_entry_t             slot_rec [TABLE_DEPTH];

  always #2 clk = ~clk;

  open_addressing_hash_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  function automatic int unsigned span_of(logic [TABLE_SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > TABLE_DEPTH) return TABLE_DEPTH;
    return 32'(v);
  endfunction

  function automatic oaht_out_t predict_answer(oaht_in_t w);
    oaht_out_t   r;
    int unsigned span;
    int unsigned home;
    int unsigned pos;
    int unsigned probes;
    int unsigned k;
    span = span_of(size_reg);
    home = w.course_number % span;
    pos = home;
    probes = 0;
    k = 1;
    r = '0;
    if (w.command == CMD_INSERT) begin
      r.status = ST_FULL;
      while (probes < span) begin
        probes++;
        if (!slot_used[pos]) begin
          slot_used[pos] = 1'b1;
          slot_rec[pos].valid = 1'b1;
          slot_rec[pos].course_year = w.course_year;
          slot_rec[pos].course_number = w.course_number;
          slot_rec[pos].prof_code = w.prof_code;
          slot_rec[pos].record_handle = w.record_handle;
          r.status = ST_INSERTED;
          r.slot_index = pos[SLOT_W-1:0];
          break;
        end
        r.collided = 1'b1;
        pos = (pos + (k * k) % span) % span;
        k++;
      end
    end else begin
      r.status = ST_NOT_FOUND;
      while (probes < span) begin
        if (probes > 0 && pos == home) break;
        probes++;
        if (!slot_used[pos]) break;
        if (slot_rec[pos].course_year == w.course_year &&
            slot_rec[pos].course_number == w.course_number &&
            slot_rec[pos].prof_code == w.prof_code) begin
          r.status = ST_FOUND;
          r.slot_index = pos[SLOT_W-1:0];
          r.found_handle = slot_rec[pos].record_handle;
          break;
        end
        pos = (pos + (k * k) % span) % span;
        k++;
      end
    end
    r.probe_count = probes[PROBE_W-1:0];
    return r;
  endfunction

  task automatic add_op(oaht_in_t w, bit steady);
    job_t j;
    j.kind = JOB_OP;
    j.word = w;
    j.size = '0;
    j.steady = steady;
    cmd_plan.insert(cmd_plan.size(), j);
    cycle_budget += 24 + 2 * span_of(planned_size);
  endtask

  task automatic add_cfg(logic [TABLE_SIZE_W-1:0] v);
    job_t j;
    j.kind = JOB_CFG;
    j.word = '0;
    j.size = v;
    j.steady = 1'b0;
    cmd_plan.insert(cmd_plan.size(), j);
    planned_size = v;
    cycle_budget += 8;
  endtask

  task automatic add_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.word = '0;
    j.size = '0;
    j.steady = 1'b0;
    cmd_plan.insert(cmd_plan.size(), j);
    cycle_budget += 8;
  endtask

  always @(negedge clk) begin
    logic                    nxt_start;
    oaht_in_t                nxt_data;
    logic                    nxt_we;
    logic [TABLE_SIZE_W-1:0] nxt_cfg;
    job_t                    j;
    nxt_start = start;
    nxt_data = in_data;
    nxt_we = 1'b0;
    nxt_cfg = cfg_data;
    if (!rst_n) begin
      nxt_start = 1'b0;
    end else begin
      if (start && in_taken) nxt_start = 1'b0;
      if (!nxt_start && cmd_plan.size() != 0) begin
        j = cmd_plan[0];
        case (j.kind)
          JOB_OP: begin
            if (j.steady || $urandom_range(99) >= 20) begin
              nxt_start = 1'b1;
              nxt_data = j.word;
              void'(cmd_plan.pop_front());
            end
          end
          JOB_CFG: begin
            if (answer_q.size() == 0 && !busy && !start) begin
              nxt_we = 1'b1;
              nxt_cfg = j.size;
              void'(cmd_plan.pop_front());
            end
          end
          default: begin
            if (answer_q.size() == 0 && !start) void'(cmd_plan.pop_front());
          end
        endcase
      end
    end
    start <= nxt_start;
    in_data <= nxt_data;
    cfg_we <= nxt_we;
    cfg_data <= nxt_cfg;
  end

  always @(posedge clk) begin
    oaht_out_t want;
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("open_addressing_hash_table: mismatch");
      $finish;
    end
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          $error("result word with none expected");
          error_count++;
        end else begin
          want = answer_q.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, out_data.slot_index);
            error_count++;
          end
          if (out_data.probe_count !== want.probe_count) begin
            $error("probe_count: expected %0d, got %0d", want.probe_count,
                   out_data.probe_count);
            error_count++;
          end
          if (out_data.collided !== want.collided) begin
            $error("collided: expected %0d, got %0d", want.collided, out_data.collided);
            error_count++;
          end
          if (out_data.found_handle !== want.found_handle) begin
            $error("found_handle: expected %0h, got %0h", want.found_handle,
                   out_data.found_handle);
            error_count++;
          end
        end
      end
      if (cfg_we) size_reg = cfg_data;
      if (start && !busy) begin
        in_taken = 1'b1;
        answer_q.insert(answer_q.size(), predict_answer(in_data));
      end
    end
  end

  initial begin
    oaht_in_t                w;
    oaht_in_t                key;
    oaht_in_t                recent[$];
    int                      pick;
    int                      n_items;
    logic [TABLE_SIZE_W-1:0] phase_sizes [18];

    phase_sizes = '{
      11'd0, 11'd1, 11'd2, 11'd3, 11'd5, 11'd8, 11'd13, 11'd16, 11'd37,
      11'd64, 11'd100, 11'd128, 11'd255, 11'd2047, 11'd1024, 11'd1500, 11'd9, 11'd300
    };

    add_op(oaht_in_t'{CMD_SEARCH, 16'd0, 12'd0, 32'd0, 16'd0}, 1'b0);
    add_op(oaht_in_t'{CMD_INSERT, 16'd0, 12'd0, 32'd0, 16'd0}, 1'b0);
    add_op(oaht_in_t'{CMD_INSERT, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0);
    add_op(oaht_in_t'{CMD_INSERT, 16'd1024, 12'd2024, 32'h1234_5678, 16'hA5A5}, 1'b0);
    add_op(oaht_in_t'{CMD_INSERT, 16'd0, 12'd0, 32'd0, 16'h5A5A}, 1'b0);
    add_op(oaht_in_t'{CMD_SEARCH, 16'd0, 12'd0, 32'd0, 16'hFFFF}, 1'b0);
    add_op(oaht_in_t'{CMD_SEARCH, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 16'd0}, 1'b0);
    add_op(oaht_in_t'{CMD_SEARCH, 16'd1024, 12'd2024, 32'h1234_5678, 16'd0}, 1'b0);
    add_op(oaht_in_t'{CMD_SEARCH, 16'd0, 12'd1, 32'd0, 16'd0}, 1'b0);
    add_op(oaht_in_t'{CMD_SEARCH, 16'd0, 12'd0, 32'h8000_0000, 16'd0}, 1'b0);
    add_cfg(11'd0);
    add_op(oaht_in_t'{CMD_INSERT, 16'd5, 12'd7, 32'd9, 16'd11}, 1'b0);
    add_op(oaht_in_t'{CMD_SEARCH, 16'd0, 12'd0, 32'd0, 16'd0}, 1'b0);
    add_op(oaht_in_t'{CMD_SEARCH, 16'd7, 12'd0, 32'd0, 16'd0}, 1'b0);
    add_cfg(11'd2047);
    add_op(oaht_in_t'{CMD_INSERT, 16'h1234, 12'h555, 32'hDEAD_BEEF, 16'h0F0F}, 1'b0);
    add_op(oaht_in_t'{CMD_SEARCH, 16'h1234, 12'h555, 32'hDEAD_BEEF, 16'd0}, 1'b0);
    add_cfg(11'd3);
    add_op(oaht_in_t'{CMD_INSERT, 16'd2, 12'd1, 32'd2, 16'd3}, 1'b0);
    add_op(oaht_in_t'{CMD_INSERT, 16'd3, 12'd1, 32'd2, 16'd4}, 1'b0);
    add_op(oaht_in_t'{CMD_SEARCH, 16'd3, 12'd1, 32'd2, 16'd0}, 1'b0);
    add_cfg(11'd5);
    add_op(oaht_in_t'{CMD_SEARCH, 16'd0, 12'd7, 32'd0, 16'd0}, 1'b0);
    add_op(oaht_in_t'{CMD_SEARCH, 16'd1024, 12'd2024, 32'h1234_5678, 16'd0}, 1'b0);

    foreach (phase_sizes[p]) begin
      add_cfg(phase_sizes[p]);
      recent.delete();
      n_items = (span_of(phase_sizes[p]) >= 512) ? 20 : 90;
      for (int i = 0; i < n_items; i++) begin
        if (p == 2 && i == n_items / 2) add_drain();
        else if ($urandom_range(99) == 0) add_drain();
        pick = $urandom_range(99);
        w.command = CMD_SEARCH;
        w.course_number = COURSE_W'($urandom);
        w.course_year = YEAR_W'($urandom);
        w.prof_code = PROF_W'($urandom);
        w.record_handle = HANDLE_W'($urandom);
        if (pick < 45) begin
          if (recent.size() != 0 && $urandom_range(9) < 2) begin
            key = recent[$urandom_range(recent.size() - 1)];
            w.course_number = key.course_number;
            w.course_year = key.course_year;
            w.prof_code = key.prof_code;
          end
          w.command = CMD_INSERT;
          recent.insert(recent.size(), w);
        end else if (pick < 90 && recent.size() != 0) begin
          key = recent[$urandom_range(recent.size() - 1)];
          w.course_number = key.course_number;
          w.course_year = key.course_year;
          w.prof_code = key.prof_code;
          if (pick >= 80) begin
            case ($urandom_range(2))
              0: w.course_number[$urandom_range(COURSE_W - 1)] ^= 1'b1;
              1: w.course_year[$urandom_range(YEAR_W - 1)] ^= 1'b1;
              default: w.prof_code[$urandom_range(PROF_W - 1)] ^= 1'b1;
            endcase
          end
        end
        add_op(w, p == 6);
      end
    end

    cycle_limit = 4 * cycle_budget + 4 * TABLE_DEPTH + 2 * TAIL_CYCLES + 10000;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_plan.size() != 0 || answer_q.size() != 0 || start) begin
      @(posedge clk);
      #1;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("open_addressing_hash_table: match");
    end else begin
      $display("open_addressing_hash_table: mismatch");
    end
    $finish;
  end

endmodule
